// ===== rtl/core/itoa_pkg.sv =====
// Shared types, character codes and the digit-to-ASCII function for the integer to text block.
package itoa_pkg;

  // Quotient bits retired per divide cycle.
  localparam int STEP_BITS = 4;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_DEC = 6'd10;

  localparam logic [6:0] CHAR_NUL         = 7'h00;
  localparam logic [6:0] CHAR_MINUS       = 7'h2d;
  localparam logic [6:0] CHAR_ZERO        = 7'h30;
  // 'a' minus ten, so that digit ten maps to 'a'.
  localparam logic [6:0] CHAR_LETTER_BASE = 7'h57;

  localparam logic [1:0] EMIT_NONE  = 2'd0;
  localparam logic [1:0] EMIT_MINUS = 2'd1;
  localparam logic [1:0] EMIT_DIGIT = 2'd2;
  localparam logic [1:0] EMIT_NUL   = 2'd3;

  typedef struct packed {
    logic       load;   // capture value and radix, clear digit count
    logic       step;   // run one divide cycle
    logic       store;  // write the finished remainder, advance digit count
    logic       dec;    // drop one digit from the count
    logic [1:0] emit;   // which character to register on the output
  } cmd_t;

  typedef struct packed {
    logic radix_ok;    // radix on the input is 2..36
    logic minus;       // input is negative and radix is ten
    logic quot_zero;   // running quotient is zero
    logic last_digit;  // one digit left in the store
  } status_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_LETTER_BASE + 7'(d);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/itoa_ctrl.sv =====
// Sequencer for the integer to text block: sign, divide loop, digit readout and terminator.
module itoa_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  itoa_pkg::status_t status,
  output itoa_pkg::cmd_t    cmd
);
  import itoa_pkg::*;

  localparam int PAD_W  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NSTEP  = PAD_W / STEP_BITS;
  localparam int SCNT_W = $clog2(NSTEP);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SIGN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_TERM  = 3'd6;

  logic [2:0]        state, state_next;
  logic [SCNT_W-1:0] step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          step_cnt_next = '0;
          if (!status.radix_ok) begin
            state_next = S_TERM;
          end else if (status.minus) begin
            state_next = S_SIGN;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_SIGN: begin
        cmd.emit   = EMIT_MINUS;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == SCNT_W'(NSTEP - 1)) begin
          cmd.store     = 1'b1;
          step_cnt_next = '0;
          state_next    = S_CHECK;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      S_CHECK: begin
        state_next = status.quot_zero ? S_READ : S_DIV;
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.emit   = EMIT_DIGIT;
        cmd.dec    = 1'b1;
        state_next = status.last_digit ? S_TERM : S_OUT;
      end
      S_TERM: begin
        cmd.emit   = EMIT_NUL;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/itoa_dp.sv =====
// Datapath for the integer to text block: radix divider, digit store and output register.
module itoa_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic        [5:0]            radix,
  input  itoa_pkg::cmd_t               cmd,
  output itoa_pkg::status_t            status,
  output logic                         strobe,
  output logic        [6:0]            character,
  output logic                         last
);
  import itoa_pkg::*;

  localparam int PAD_W  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  logic [PAD_W-1:0]      dq;
  logic [5:0]            rem;
  logic [5:0]            base;
  logic [CNT_W-1:0]      count, count_next;
  logic [ADDR_W-1:0]     rd_addr;
  logic [5:0]            rd_data;
  logic [5:0]            mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] mag;
  logic [6:0]            r;
  logic [PAD_W-1:0]      q;
  logic [5:0]            step_rem;
  logic [PAD_W-1:0]      step_q;

  // Magnitude as unsigned; the most negative value maps to its exact magnitude.
  assign mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // Restoring division, STEP_BITS quotient bits per cycle.
  always_comb begin
    r = {1'b0, rem};
    q = dq;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[5:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, base}) begin
        r    = r - {1'b0, base};
        q[0] = 1'b1;
      end
    end
    step_rem = r[5:0];
    step_q   = q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq   <= PAD_W'(mag);
      rem  <= '0;
      base <= radix;
    end else if (cmd.step) begin
      dq  <= step_q;
      rem <= cmd.store ? 6'd0 : step_rem;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.load) begin
      count_next = '0;
    end else if (cmd.store) begin
      count_next = count + 1'b1;
    end else if (cmd.dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Read ahead at the top digit of the next count so readout runs one per cycle.
  assign rd_addr = ADDR_W'(count_next - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[ADDR_W-1:0]] <= step_rem;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    status.radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    status.minus      = value[VALUE_BITS-1] && (radix == RADIX_DEC);
    status.quot_zero  = (dq == '0);
    status.last_digit = (count == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_MINUS: begin
        character <= CHAR_MINUS;
        last      <= 1'b0;
      end
      EMIT_DIGIT: begin
        character <= digit_char(rd_data);
        last      <= 1'b0;
      end
      EMIT_NUL: begin
        character <= CHAR_NUL;
        last      <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/integer_to_text_any_base_top.sv =====
// Integer to text in any base: top level joining the sequencer and the datapath.
// The '-' comes out before the divide loop runs; the digits follow once the quotient reaches zero.
// One item runs the divide loop once per digit, and no new start is taken while busy;
// the radix divider retires 4 quotient bits per cycle.
// A bad radix gives the NUL alone; start is taken again in the cycle that shows it.
// rst clears control state and the output strobe; results cannot be stalled.
module integer_to_text_any_base_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic        [5:0]            radix,
  output logic                         strobe,
  output logic        [6:0]            character,
  output logic                         last
);
  import itoa_pkg::*;

  // Commands flow from the sequencer into the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  // Sequencer: accepts a beat when idle, emits any '-', runs the divide loop one digit
  // at a time, then walks the digit store from the top down and closes with NUL.
  itoa_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath: holds the running quotient and remainder, stores digits least
  // significant first, and registers each result beat for one cycle.
  itoa_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .radix     (radix),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

// ===== rtl/core/itoa_check.sv =====
// Port-level checks for the integer to text block, bound to its top level.
module itoa_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [6:0] character,
  input logic       last
);
  import itoa_pkg::*;

  // An accepted beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // The terminator is always the NUL character.
  a_last_nul: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> character == CHAR_NUL)
    else $error("last beat is not NUL");

  // A non-final character shows only while a conversion is still in flight.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final character while idle");

  // Going idle coincides with the terminator beat.
  a_idle_term: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("block went idle without a terminator");

endmodule

bind integer_to_text_any_base_top itoa_check u_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);
